>>> design/nws_pkg.sv
// Shared constants, codes and control types for the nearest waypoint search block.
`default_nettype none

package nws_pkg;

   // Table depth default and fixed field widths
   localparam int MAX_POINTS_DEFAULT = 1024;
   localparam int MODE_W             = 2;
   localparam int COORD_W            = 32;
   localparam int INDEX_OUT_W        = 10;
   localparam int COUNT_OUT_W        = 11;
   localparam int SQ_W               = 2 * COORD_W;
   localparam int DIST_W             = SQ_W + 1;

   // Item operation codes
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SCAN_DRAIN,
      ST_RD_CHOSEN,
      ST_RD_NEXT,
      ST_WAIT_NEXT,
      ST_INJ_SEG,
      ST_ADV_DRAIN,
      ST_RESULT
   } ctrl_state_type;

   // What a table read is for
   typedef enum logic [1:0] {
      RD_SCAN,
      RD_CHOSEN,
      RD_NEXT
   } rd_kind_type;

   // What a distance result is for
   typedef enum logic [1:0] {
      TAG_SCAN,
      TAG_SEG,
      TAG_VEH
   } dist_tag_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic query_start;
      logic rd_scan;
      logic rd_chosen;
      logic rd_next;
      logic inject_seg;
      logic load_rsp;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_query;
      logic count_zero;
      logic scan_last;
      logic has_next;
      logic busy;
   } dp_status_type;

endpackage

`default_nettype wire

>>> design/nws_dist.sv
// Pipelined exact squared-distance unit with a tag and index riding along.
`default_nettype none

module nws_dist #(
   parameter int IDX_W = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_vld,
   input  wire nws_pkg::dist_tag_type             in_tag,
   input  wire logic [IDX_W-1:0]                  in_idx,
   input  wire logic signed [nws_pkg::COORD_W-1:0] in_ax,
   input  wire logic signed [nws_pkg::COORD_W-1:0] in_ay,
   input  wire logic signed [nws_pkg::COORD_W-1:0] in_bx,
   input  wire logic signed [nws_pkg::COORD_W-1:0] in_by,
   output logic                                   out_vld,
   output nws_pkg::dist_tag_type                  out_tag,
   output logic [IDX_W-1:0]                       out_idx,
   output logic [nws_pkg::DIST_W-1:0]             out_dist,
   output logic                                   busy
);

   localparam int DIFF_W = nws_pkg::COORD_W + 1;

   // Stage valids
   logic                          d_vld_ff, a_vld_ff, m_vld_ff, s_vld_ff;
   // Tags and indexes per stage
   nws_pkg::dist_tag_type         d_tag_ff, a_tag_ff, m_tag_ff, s_tag_ff;
   logic [IDX_W-1:0]              d_idx_ff, a_idx_ff, m_idx_ff, s_idx_ff;
   // Payload per stage
   logic signed [DIFF_W-1:0]      dx_ff, dy_ff, dx_in, dy_in;
   logic [nws_pkg::COORD_W-1:0]   abs_x_ff, abs_y_ff, abs_x_in, abs_y_in;
   logic [nws_pkg::SQ_W-1:0]      sq_x_ff, sq_y_ff, sq_x_in, sq_y_in;
   logic [nws_pkg::DIST_W-1:0]    sum_ff, sum_in;

   // Sign-extended differences
   assign dx_in = DIFF_W'(in_ax) - DIFF_W'(in_bx);
   assign dy_in = DIFF_W'(in_ay) - DIFF_W'(in_by);

   // Magnitudes fit 32 bits: the largest gap is 2^32 - 1
   assign abs_x_in = dx_ff[DIFF_W-1] ? nws_pkg::COORD_W'(-dx_ff) : dx_ff[nws_pkg::COORD_W-1:0];
   assign abs_y_in = dy_ff[DIFF_W-1] ? nws_pkg::COORD_W'(-dy_ff) : dy_ff[nws_pkg::COORD_W-1:0];

   // Squares, one 32x32 multiplier per axis
   assign sq_x_in = nws_pkg::SQ_W'(abs_x_ff) * nws_pkg::SQ_W'(abs_x_ff);
   assign sq_y_in = nws_pkg::SQ_W'(abs_y_ff) * nws_pkg::SQ_W'(abs_y_ff);

   // Sum with carry kept
   assign sum_in = nws_pkg::DIST_W'(sq_x_ff) + nws_pkg::DIST_W'(sq_y_ff);

   // Advance valids
   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
         a_vld_ff <= 1'b0;
         m_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= in_vld;
         a_vld_ff <= d_vld_ff;
         m_vld_ff <= a_vld_ff;
         s_vld_ff <= m_vld_ff;
      end
   end

   // Advance payload, tags and indexes
   always_ff @(posedge clock) begin
      d_tag_ff <= in_tag;
      d_idx_ff <= in_idx;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      a_tag_ff <= d_tag_ff;
      a_idx_ff <= d_idx_ff;
      abs_x_ff <= abs_x_in;
      abs_y_ff <= abs_y_in;
      m_tag_ff <= a_tag_ff;
      m_idx_ff <= a_idx_ff;
      sq_x_ff  <= sq_x_in;
      sq_y_ff  <= sq_y_in;
      s_tag_ff <= m_tag_ff;
      s_idx_ff <= m_idx_ff;
      sum_ff   <= sum_in;
   end

   assign out_vld  = s_vld_ff;
   assign out_tag  = s_tag_ff;
   assign out_idx  = s_idx_ff;
   assign out_dist = sum_ff;
   assign busy     = d_vld_ff | a_vld_ff | m_vld_ff | s_vld_ff;

endmodule

`default_nettype wire

>>> design/nws_ctrl.sv
// Sequencing state machine for item execution, table scan, advance check and result beat.
`default_nettype none

module nws_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire nws_pkg::dp_status_type status,
   output nws_pkg::ctrl_cmd_type       cmd
);

   nws_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nws_pkg::ST_IDLE: begin
            if (req_valid) state_in = nws_pkg::ST_EXEC;
         end
         nws_pkg::ST_EXEC: begin
            if (status.is_query && !status.count_zero) state_in = nws_pkg::ST_SCAN;
            else state_in = nws_pkg::ST_RESULT;
         end
         nws_pkg::ST_SCAN: begin
            if (status.scan_last) state_in = nws_pkg::ST_SCAN_DRAIN;
         end
         nws_pkg::ST_SCAN_DRAIN: begin
            if (!status.busy) state_in = nws_pkg::ST_RD_CHOSEN;
         end
         nws_pkg::ST_RD_CHOSEN: begin
            state_in = nws_pkg::ST_RD_NEXT;
         end
         nws_pkg::ST_RD_NEXT: begin
            if (status.has_next) state_in = nws_pkg::ST_WAIT_NEXT;
            else state_in = nws_pkg::ST_ADV_DRAIN;
         end
         nws_pkg::ST_WAIT_NEXT: begin
            state_in = nws_pkg::ST_INJ_SEG;
         end
         nws_pkg::ST_INJ_SEG: begin
            state_in = nws_pkg::ST_ADV_DRAIN;
         end
         nws_pkg::ST_ADV_DRAIN: begin
            if (!status.busy) state_in = nws_pkg::ST_RESULT;
         end
         nws_pkg::ST_RESULT: begin
            if (slot_free) state_in = nws_pkg::ST_IDLE;
         end
         default: begin
            state_in = nws_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands per state
   always_comb begin
      cmd = '0;
      case (state_ff)
         nws_pkg::ST_IDLE: begin
            cmd.capture = req_valid;
         end
         nws_pkg::ST_EXEC: begin
            cmd.exec        = 1'b1;
            cmd.query_start = status.is_query && !status.count_zero;
         end
         nws_pkg::ST_SCAN: begin
            cmd.rd_scan = 1'b1;
         end
         nws_pkg::ST_RD_CHOSEN: begin
            cmd.rd_chosen = 1'b1;
         end
         nws_pkg::ST_RD_NEXT: begin
            cmd.rd_next = status.has_next;
         end
         nws_pkg::ST_INJ_SEG: begin
            cmd.inject_seg = 1'b1;
         end
         nws_pkg::ST_RESULT: begin
            cmd.load_rsp = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Result beat valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nws_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != nws_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> design/nws_dp.sv
// Waypoint table, point count, scan tracking, advance check and result registers.
`default_nettype none

module nws_dp #(
   parameter int MAX_POINTS = nws_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire nws_pkg::ctrl_cmd_type               cmd,
   output nws_pkg::dp_status_type                   status,
   input  wire logic [nws_pkg::MODE_W-1:0]          req_mode,
   input  wire logic signed [nws_pkg::COORD_W-1:0]  req_pos_x,
   input  wire logic signed [nws_pkg::COORD_W-1:0]  req_pos_y,
   output logic [nws_pkg::INDEX_OUT_W-1:0]          rsp_target_idx,
   output logic signed [nws_pkg::COORD_W-1:0]       rsp_target_x,
   output logic signed [nws_pkg::COORD_W-1:0]       rsp_target_y,
   output logic                                     rsp_valid_res,
   output logic [nws_pkg::COUNT_OUT_W-1:0]          rsp_point_count,
   output logic                                     rsp_overflow
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int CMP_W = CNT_W + 1;

   // Captured item
   logic [nws_pkg::MODE_W-1:0]         mode_ff;
   logic signed [nws_pkg::COORD_W-1:0] veh_x_ff, veh_y_ff;

   // Table state
   logic signed [nws_pkg::COORD_W-1:0] wp_x_ff [MAX_POINTS];
   logic signed [nws_pkg::COORD_W-1:0] wp_y_ff [MAX_POINTS];
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic                               ovf_ff, ovf_in;
   logic                               full, do_write;

   // Read port
   logic                               rd_en;
   logic [IDX_W-1:0]                   rd_addr;
   nws_pkg::rd_kind_type               rd_kind;
   logic                               rd_vld_ff;
   nws_pkg::rd_kind_type               rd_kind_ff;
   logic [IDX_W-1:0]                   rd_idx_ff;
   logic signed [nws_pkg::COORD_W-1:0] rd_x_ff, rd_y_ff;

   // Scan and advance
   logic [IDX_W-1:0]                   scan_addr_ff;
   logic                               best_vld_ff;
   logic [IDX_W-1:0]                   best_idx_ff;
   logic [nws_pkg::DIST_W-1:0]         best_dist_ff, seg_ff, veh_ff;
   logic signed [nws_pkg::COORD_W-1:0] chosen_x_ff, chosen_y_ff, next_x_ff, next_y_ff;
   logic [CMP_W-1:0]                   best_plus1, scan_plus1;

   // Distance unit hookup
   logic                               di_vld;
   nws_pkg::dist_tag_type              di_tag;
   logic [IDX_W-1:0]                   di_idx;
   logic signed [nws_pkg::COORD_W-1:0] di_ax, di_ay, di_bx, di_by;
   logic                               do_vld;
   nws_pkg::dist_tag_type              do_tag;
   logic [IDX_W-1:0]                   do_idx;
   logic [nws_pkg::DIST_W-1:0]         do_dist;
   logic                               dist_busy;

   // Result
   logic                               found, adv;
   logic [IDX_W-1:0]                   res_idx;
   logic [IDX_W+nws_pkg::INDEX_OUT_W-1:0] idx_wide;
   logic [CNT_W+nws_pkg::COUNT_OUT_W-1:0] cnt_wide;

   // Capture the accepted beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         veh_x_ff <= req_pos_x;
         veh_y_ff <= req_pos_y;
      end
   end

   // Clear, append and overflow flag
   assign full     = (count_ff == CNT_W'(MAX_POINTS));
   assign do_write = cmd.exec && (mode_ff == nws_pkg::MODE_APPEND) && !full;

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.exec) begin
         ovf_in = 1'b0;
         case (mode_ff)
            nws_pkg::MODE_CLEAR: begin
               count_in = '0;
            end
            nws_pkg::MODE_APPEND: begin
               if (full) ovf_in = 1'b1;
               else count_in = count_ff + CNT_W'(1);
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Read address select
   assign best_plus1 = CMP_W'(best_idx_ff) + CMP_W'(1);
   assign scan_plus1 = CMP_W'(scan_addr_ff) + CMP_W'(1);
   assign rd_en      = cmd.rd_scan | cmd.rd_chosen | cmd.rd_next;

   always_comb begin
      rd_addr = scan_addr_ff;
      rd_kind = nws_pkg::RD_SCAN;
      if (cmd.rd_chosen) begin
         rd_addr = best_idx_ff;
         rd_kind = nws_pkg::RD_CHOSEN;
      end else if (cmd.rd_next) begin
         rd_addr = best_plus1[IDX_W-1:0];
         rd_kind = nws_pkg::RD_NEXT;
      end
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         wp_x_ff[count_ff[IDX_W-1:0]] <= veh_x_ff;
         wp_y_ff[count_ff[IDX_W-1:0]] <= veh_y_ff;
      end
      if (rd_en) begin
         rd_x_ff <= wp_x_ff[rd_addr];
         rd_y_ff <= wp_y_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_kind_ff <= rd_kind;
      rd_idx_ff  <= rd_addr;
   end

   // Scan address counter
   always_ff @(posedge clock) begin
      if (cmd.query_start) scan_addr_ff <= '0;
      else if (cmd.rd_scan) scan_addr_ff <= scan_addr_ff + IDX_W'(1);
   end

   // Hold the chosen and next waypoints as their reads return
   always_ff @(posedge clock) begin
      if (rd_vld_ff && (rd_kind_ff == nws_pkg::RD_CHOSEN)) begin
         chosen_x_ff <= rd_x_ff;
         chosen_y_ff <= rd_y_ff;
      end
      if (rd_vld_ff && (rd_kind_ff == nws_pkg::RD_NEXT)) begin
         next_x_ff <= rd_x_ff;
         next_y_ff <= rd_y_ff;
      end
   end

   // Feed the distance unit: scan points and the next point against the vehicle,
   // or the segment from the chosen point to the next
   always_comb begin
      di_vld = 1'b0;
      di_tag = nws_pkg::TAG_SCAN;
      di_idx = rd_idx_ff;
      di_ax  = veh_x_ff;
      di_ay  = veh_y_ff;
      di_bx  = rd_x_ff;
      di_by  = rd_y_ff;
      if (cmd.inject_seg) begin
         di_vld = 1'b1;
         di_tag = nws_pkg::TAG_SEG;
         di_ax  = next_x_ff;
         di_ay  = next_y_ff;
         di_bx  = chosen_x_ff;
         di_by  = chosen_y_ff;
      end else if (rd_vld_ff && (rd_kind_ff == nws_pkg::RD_SCAN)) begin
         di_vld = 1'b1;
      end else if (rd_vld_ff && (rd_kind_ff == nws_pkg::RD_NEXT)) begin
         di_vld = 1'b1;
         di_tag = nws_pkg::TAG_VEH;
      end
   end

   nws_dist #(
      .IDX_W (IDX_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (di_vld),
      .in_tag   (di_tag),
      .in_idx   (di_idx),
      .in_ax    (di_ax),
      .in_ay    (di_ay),
      .in_bx    (di_bx),
      .in_by    (di_by),
      .out_vld  (do_vld),
      .out_tag  (do_tag),
      .out_idx  (do_idx),
      .out_dist (do_dist),
      .busy     (dist_busy)
   );

   // Keep the running minimum; strict compare keeps the first of equal points
   always_ff @(posedge clock) begin
      if (reset) begin
         best_vld_ff <= 1'b0;
      end else if (cmd.query_start) begin
         best_vld_ff <= 1'b0;
      end else if (do_vld && (do_tag == nws_pkg::TAG_SCAN)) begin
         best_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_vld) begin
         case (do_tag)
            nws_pkg::TAG_SCAN: begin
               if (!best_vld_ff || (do_dist < best_dist_ff)) begin
                  best_dist_ff <= do_dist;
                  best_idx_ff  <= do_idx;
               end
            end
            nws_pkg::TAG_SEG: begin
               seg_ff <= do_dist;
            end
            nws_pkg::TAG_VEH: begin
               veh_ff <= do_dist;
            end
            default: begin
               seg_ff <= seg_ff;
            end
         endcase
      end
   end

   // Status back to the controller
   assign status.is_query   = (mode_ff == nws_pkg::MODE_QUERY);
   assign status.count_zero = (count_ff == '0);
   assign status.scan_last  = (scan_plus1 == CMP_W'(count_ff));
   assign status.has_next   = (best_plus1 < CMP_W'(count_ff));
   assign status.busy       = rd_vld_ff | dist_busy;

   // Advance when the vehicle is strictly closer to the next point than the segment
   assign found    = status.is_query && !status.count_zero;
   assign adv      = status.has_next && (veh_ff < seg_ff);
   assign res_idx  = best_idx_ff + IDX_W'(adv);
   assign idx_wide = {{nws_pkg::INDEX_OUT_W{1'b0}}, res_idx};
   assign cnt_wide = {{nws_pkg::COUNT_OUT_W{1'b0}}, count_ff};

   // Result registers
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_target_idx   <= found ? idx_wide[nws_pkg::INDEX_OUT_W-1:0] : '0;
         rsp_target_x     <= found ? (adv ? next_x_ff : chosen_x_ff) : '0;
         rsp_target_y     <= found ? (adv ? next_y_ff : chosen_y_ff) : '0;
         rsp_valid_res    <= found;
         rsp_point_count  <= cnt_wide[nws_pkg::COUNT_OUT_W-1:0];
         rsp_overflow     <= ovf_ff;
      end
   end

endmodule

`default_nettype wire

>>> design/nearest_waypoint_search.sv
// Top level of the nearest waypoint search: controller and datapath.
//
//   Channel | Dir | Handshake            | Beat contents
//   req     | in  | req_valid/req_stall  | mode, pos_x, pos_y
//   rsp     | out | rsp_valid/rsp_stall  | target_idx, target_x, target_y,
//           |     |                      | valid_res, point_count, overflow
//
// Clear, append, mode-three and empty-table query beats go from accept through the
// execute state straight to result load, with no table scan.
// A query on N stored points first scans the table one entry per cycle, then the
// 4-stage distance pipeline drains twice, after the scan and after the advance
// check; when the chosen point is the last, no next point is read and the result
// stays on the chosen point.
// Reset is synchronous and empties the table; the table contents are not cleared.
// One item is in flight at a time; a stalled result holds its register, and the
// next beat is taken once the controller is back in idle.
`default_nettype none

module nearest_waypoint_search #(
   parameter int MAX_POINTS = nws_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [nws_pkg::MODE_W-1:0]          req_mode,
   input  wire logic signed [nws_pkg::COORD_W-1:0]  req_pos_x,
   input  wire logic signed [nws_pkg::COORD_W-1:0]  req_pos_y,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [nws_pkg::INDEX_OUT_W-1:0]          rsp_target_idx,
   output logic signed [nws_pkg::COORD_W-1:0]       rsp_target_x,
   output logic signed [nws_pkg::COORD_W-1:0]       rsp_target_y,
   output logic                                     rsp_valid_res,
   output logic [nws_pkg::COUNT_OUT_W-1:0]          rsp_point_count,
   output logic                                     rsp_overflow
);

   nws_pkg::ctrl_cmd_type  cmd;
   nws_pkg::dp_status_type status;

   nws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   nws_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .rsp_target_idx   (rsp_target_idx),
      .rsp_target_x     (rsp_target_x),
      .rsp_target_y     (rsp_target_y),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_point_count  (rsp_point_count),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

`default_nettype wire

>>> design/nws_checker.sv
// Port-level checks for the nearest waypoint search, bound to the top level.
`default_nettype none

module nws_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [nws_pkg::INDEX_OUT_W-1:0]     rsp_target_idx,
   input wire logic signed [nws_pkg::COORD_W-1:0]  rsp_target_x,
   input wire logic signed [nws_pkg::COORD_W-1:0]  rsp_target_y,
   input wire logic                                rsp_valid_res,
   input wire logic [nws_pkg::COUNT_OUT_W-1:0]     rsp_point_count,
   input wire logic                                rsp_overflow
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_target_idx)
         && $stable(rsp_target_x) && $stable(rsp_target_y) && $stable(rsp_valid_res)
         && $stable(rsp_point_count) && $stable(rsp_overflow))
      else $error("result beat changed while stalled");

   // One item at a time: after a taken beat the input stalls
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // No target reported without a found waypoint
   a_no_target_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> (rsp_target_idx == '0)
         && (rsp_target_x == '0) && (rsp_target_y == '0))
      else $error("target fields set on a result without a target");

   // A refused append never comes with a target
   a_ovf_no_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> !rsp_valid_res)
      else $error("overflow and target on one result");

endmodule

bind nearest_waypoint_search nws_checker u_nws_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_target_idx   (rsp_target_idx),
   .rsp_target_x     (rsp_target_x),
   .rsp_target_y     (rsp_target_y),
   .rsp_valid_res    (rsp_valid_res),
   .rsp_point_count  (rsp_point_count),
   .rsp_overflow     (rsp_overflow)
);

`default_nettype wire

>>> test/nearest_waypoint_search_test.sv
// Self-checking bench for the nearest waypoint search: directed table, then random paths.
`timescale 1ns / 100ps

module nearest_waypoint_search_test;

   localparam int TABLE_DEPTH = nws_pkg::MAX_POINTS_DEFAULT;
   localparam logic [nws_pkg::MODE_W-1:0] MODE_IGNORED = 2'd3;

   // One result beat, field for field
   typedef struct packed {
      logic [nws_pkg::INDEX_OUT_W-1:0]    index;
      logic signed [nws_pkg::COORD_W-1:0] x;
      logic signed [nws_pkg::COORD_W-1:0] y;
      logic                               found;
      logic [nws_pkg::COUNT_OUT_W-1:0]    count;
      logic                               refused;
   } target_beat_type;

   // One row of the directed table
   typedef struct {
      logic [nws_pkg::MODE_W-1:0]         mode;
      logic signed [nws_pkg::COORD_W-1:0] x;
      logic signed [nws_pkg::COORD_W-1:0] y;
      bit                                 typed;
      target_beat_type                    want;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [nws_pkg::MODE_W-1:0] req_mode = '0;
   logic signed [nws_pkg::COORD_W-1:0] req_pos_x = '0;
   logic signed [nws_pkg::COORD_W-1:0] req_pos_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [nws_pkg::INDEX_OUT_W-1:0] rsp_target_idx;
   logic signed [nws_pkg::COORD_W-1:0] rsp_target_x;
   logic signed [nws_pkg::COORD_W-1:0] rsp_target_y;
   logic rsp_valid_res;
   logic [nws_pkg::COUNT_OUT_W-1:0] rsp_point_count;
   logic rsp_overflow;

   // Predicted waypoint table
   logic signed [nws_pkg::COORD_W-1:0] path_x [TABLE_DEPTH];
   logic signed [nws_pkg::COORD_W-1:0] path_y [TABLE_DEPTH];
   int path_len = 0;

   target_beat_type awaited_targets [$];
   probe_row_type probe_plan [$];
   int mismatch_count = 0;
   int sent_items = 0;
   int send_idle_pct = 20;
   int stall_pct = 48;

   // Path walker for random waypoints
   logic signed [nws_pkg::COORD_W-1:0] walk_x = '0;
   logic signed [nws_pkg::COORD_W-1:0] walk_y = '0;
   int unsigned walk_span = 3;

   nearest_waypoint_search #(
      .MAX_POINTS(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_target_idx(rsp_target_idx),
      .rsp_target_x(rsp_target_x),
      .rsp_target_y(rsp_target_y),
      .rsp_valid_res(rsp_valid_res),
      .rsp_point_count(rsp_point_count),
      .rsp_overflow(rsp_overflow)
   );

   always #6 clock = ~clock;

   // Exact squared distance; the top bit is the carry of the sum
   function automatic logic [nws_pkg::DIST_W-1:0] sq_span(
         logic signed [nws_pkg::COORD_W-1:0] ax, logic signed [nws_pkg::COORD_W-1:0] ay,
         logic signed [nws_pkg::COORD_W-1:0] bx, logic signed [nws_pkg::COORD_W-1:0] by);
      logic signed [nws_pkg::COORD_W:0] dx, dy;
      logic [nws_pkg::COORD_W:0] mx, my;
      logic [nws_pkg::DIST_W-1:0] sum;
      dx = {ax[nws_pkg::COORD_W-1], ax} - {bx[nws_pkg::COORD_W-1], bx};
      dy = {ay[nws_pkg::COORD_W-1], ay} - {by[nws_pkg::COORD_W-1], by};
      mx = dx[nws_pkg::COORD_W] ? -dx : dx;
      my = dy[nws_pkg::COORD_W] ? -dy : dy;
      sum = nws_pkg::DIST_W'(mx) * nws_pkg::DIST_W'(mx)
          + nws_pkg::DIST_W'(my) * nws_pkg::DIST_W'(my);
      return sum;
   endfunction

   // Apply one accepted beat to the predicted table and return its result
   function automatic target_beat_type step_path(logic [nws_pkg::MODE_W-1:0] m,
                                                 logic signed [nws_pkg::COORD_W-1:0] x,
                                                 logic signed [nws_pkg::COORD_W-1:0] y);
      target_beat_type r;
      int best_i;
      logic [nws_pkg::DIST_W-1:0] best_d, d, seg_d, veh_d;
      r = '0;
      case (m)
         nws_pkg::MODE_CLEAR: begin
            path_len = 0;
         end
         nws_pkg::MODE_APPEND: begin
            if (path_len < TABLE_DEPTH) begin
               path_x[path_len] = x;
               path_y[path_len] = y;
               path_len++;
            end else begin
               r.refused = 1'b1;
            end
         end
         nws_pkg::MODE_QUERY: begin
            if (path_len > 0) begin
               best_i = 0;
               best_d = sq_span(x, y, path_x[0], path_y[0]);
               // strict compare keeps the lower index on a tie
               for (int i = 1; i < path_len; i++) begin
                  d = sq_span(x, y, path_x[i], path_y[i]);
                  if (d < best_d) begin
                     best_d = d;
                     best_i = i;
                  end
               end
               // advance when the vehicle is strictly closer to the next point
               if (best_i + 1 < path_len) begin
                  seg_d = sq_span(path_x[best_i+1], path_y[best_i+1],
                                  path_x[best_i], path_y[best_i]);
                  veh_d = sq_span(x, y, path_x[best_i+1], path_y[best_i+1]);
                  if (veh_d < seg_d) best_i++;
               end
               r.index = best_i[nws_pkg::INDEX_OUT_W-1:0];
               r.x = path_x[best_i];
               r.y = path_y[best_i];
               r.found = 1'b1;
            end
         end
         default: ;
      endcase
      r.count = path_len[nws_pkg::COUNT_OUT_W-1:0];
      return r;
   endfunction

   function automatic target_beat_type mk(int idx, logic signed [nws_pkg::COORD_W-1:0] x,
                                          logic signed [nws_pkg::COORD_W-1:0] y, int found,
                                          int count, int refused);
      target_beat_type r;
      r.index = idx[nws_pkg::INDEX_OUT_W-1:0];
      r.x = x;
      r.y = y;
      r.found = (found != 0);
      r.count = count[nws_pkg::COUNT_OUT_W-1:0];
      r.refused = (refused != 0);
      return r;
   endfunction

   function automatic logic signed [nws_pkg::COORD_W-1:0] extreme_coord();
      case ($urandom_range(3))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'sh0;
         default: return -32'sd1;
      endcase
   endfunction

   function automatic logic signed [nws_pkg::COORD_W-1:0] jitter(
         logic signed [nws_pkg::COORD_W-1:0] base, int unsigned span);
      return base + $signed($urandom_range(2 * span)) - $signed(span);
   endfunction

   // Mostly a random walk, sometimes a far jump or a corner of the range
   task automatic pick_waypoint(output logic signed [nws_pkg::COORD_W-1:0] x,
                                output logic signed [nws_pkg::COORD_W-1:0] y);
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) begin
         walk_x = jitter(walk_x, walk_span);
         walk_y = jitter(walk_y, walk_span);
         x = walk_x;
         y = walk_y;
      end else if (pick < 90) begin
         x = $urandom;
         y = $urandom;
      end else begin
         x = extreme_coord();
         y = extreme_coord();
      end
   endtask

   // Vehicle near the stored path; midpoints and exact hits force ties
   task automatic pick_vehicle(output logic signed [nws_pkg::COORD_W-1:0] x,
                               output logic signed [nws_pkg::COORD_W-1:0] y);
      int pick, k;
      pick = $urandom_range(99);
      if (path_len == 0 || pick < 15) begin
         x = $urandom;
         y = $urandom;
      end else if (pick < 25) begin
         x = extreme_coord();
         y = extreme_coord();
      end else begin
         k = $urandom_range(path_len - 1);
         if (pick < 40 && k + 1 < path_len) begin
            x = 32'((longint'(path_x[k]) + longint'(path_x[k+1])) >>> 1);
            y = 32'((longint'(path_y[k]) + longint'(path_y[k+1])) >>> 1);
         end else if (pick < 50) begin
            x = path_x[k];
            y = path_y[k];
         end else begin
            x = jitter(path_x[k], walk_span);
            y = jitter(path_y[k], walk_span);
         end
      end
   endtask

   // Drive one beat from a falling edge, hold it until accepted, record the expectation
   task automatic send_beat(input logic [nws_pkg::MODE_W-1:0] m,
                            input logic signed [nws_pkg::COORD_W-1:0] x,
                            input logic signed [nws_pkg::COORD_W-1:0] y, input bit typed,
                            input target_beat_type want);
      target_beat_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_mode <= nws_pkg::MODE_W'($urandom);
         req_pos_x <= $urandom;
         req_pos_y <= $urandom;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_pos_x <= x;
      req_pos_y <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = step_path(m, x, y);
      awaited_targets.insert(awaited_targets.size(), typed ? want : predicted);
      if (m != MODE_IGNORED) sent_items++;
      @(negedge clock);
   endtask

   task automatic issue(input logic [nws_pkg::MODE_W-1:0] m,
                        input logic signed [nws_pkg::COORD_W-1:0] x,
                        input logic signed [nws_pkg::COORD_W-1:0] y);
      send_beat(m, x, y, 1'b0, '0);
   endtask

   // Drop valid and hold until every awaited result has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (awaited_targets.size() != 0) @(negedge clock);
   endtask

   task automatic plan(input logic [nws_pkg::MODE_W-1:0] m,
                       input logic signed [nws_pkg::COORD_W-1:0] x,
                       input logic signed [nws_pkg::COORD_W-1:0] y, input bit typed,
                       input target_beat_type want);
      probe_row_type row;
      row.mode = m;
      row.x = x;
      row.y = y;
      row.typed = typed;
      row.want = want;
      probe_plan.insert(probe_plan.size(), row);
   endtask

   // Corners, ties, the strict advance rule, carry out of the distance sum
   task automatic build_probe_plan();
      plan(nws_pkg::MODE_QUERY, 5, 5, 1'b1, mk(0, 0, 0, 0, 0, 0));
      plan(MODE_IGNORED, -1, -1, 1'b1, mk(0, 0, 0, 0, 0, 0));
      plan(nws_pkg::MODE_APPEND, 0, 0, 1'b1, mk(0, 0, 0, 0, 1, 0));
      plan(nws_pkg::MODE_QUERY, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1, mk(0, 0, 0, 1, 1, 0));
      plan(nws_pkg::MODE_APPEND, 2, 0, 1'b1, mk(0, 0, 0, 0, 2, 0));
      // vehicle exactly as far from the next point as the chosen one: no advance
      plan(nws_pkg::MODE_QUERY, 0, 0, 1'b1, mk(0, 0, 0, 1, 2, 0));
      plan(nws_pkg::MODE_QUERY, 1, 0, 1'b0, '0);
      plan(nws_pkg::MODE_QUERY, 3, 0, 1'b0, '0);
      plan(nws_pkg::MODE_CLEAR, 9, 9, 1'b1, mk(0, 0, 0, 0, 0, 0));
      plan(nws_pkg::MODE_APPEND, -1, 0, 1'b1, mk(0, 0, 0, 0, 1, 0));
      plan(nws_pkg::MODE_APPEND, -3, 0, 1'b1, mk(0, 0, 0, 0, 2, 0));
      plan(nws_pkg::MODE_APPEND, 1, 0, 1'b1, mk(0, 0, 0, 0, 3, 0));
      // tie between first and last point, lower index kept
      plan(nws_pkg::MODE_QUERY, 0, 0, 1'b1, mk(0, -1, 0, 1, 3, 0));
      plan(MODE_IGNORED, 32'sh7FFFFFFF, 32'sh80000000, 1'b1, mk(0, 0, 0, 0, 3, 0));
      plan(nws_pkg::MODE_CLEAR, 0, 0, 1'b1, mk(0, 0, 0, 0, 0, 0));
      plan(nws_pkg::MODE_APPEND, 32'sh80000000, 32'sh80000000, 1'b1, mk(0, 0, 0, 0, 1, 0));
      plan(nws_pkg::MODE_APPEND, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1, mk(0, 0, 0, 0, 2, 0));
      plan(nws_pkg::MODE_APPEND, 32'sh80000000, 32'sh7FFFFFFF, 1'b1, mk(0, 0, 0, 0, 3, 0));
      plan(nws_pkg::MODE_APPEND, 32'sh7FFFFFFF, 32'sh80000000, 1'b1, mk(0, 0, 0, 0, 4, 0));
      plan(nws_pkg::MODE_QUERY, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, '0);
      plan(nws_pkg::MODE_QUERY, 32'sh80000000, 32'sh80000000, 1'b0, '0);
      plan(nws_pkg::MODE_QUERY, 0, 0, 1'b0, '0);
      plan(nws_pkg::MODE_QUERY, 32'sh80000000, 32'sh7FFFFFFF, 1'b0, '0);
      plan(nws_pkg::MODE_APPEND, 32'sh55555555, 32'shAAAAAAAA, 1'b1, mk(0, 0, 0, 0, 5, 0));
      plan(nws_pkg::MODE_QUERY, -1, -1, 1'b0, '0);
   endtask

   // Random paths: mostly clear, a run of appends, then a few queries, with some noise
   task automatic run_routes(input int goal);
      int stop, legs, asks, pick;
      logic signed [nws_pkg::COORD_W-1:0] x, y;
      stop = sent_items + goal;
      while (sent_items < stop) begin
         if (path_len > 300 || $urandom_range(9) < 8)
            issue(nws_pkg::MODE_CLEAR, $urandom, $urandom);
         case ($urandom_range(3))
            0: walk_span = 3;
            1: walk_span = 'h100;
            2: walk_span = 'h10000;
            default: walk_span = 'h1000000;
         endcase
         walk_x = $urandom;
         walk_y = $urandom;
         pick = $urandom_range(99);
         if (pick < 5) legs = 0;
         else if (pick < 15) legs = $urandom_range(25, 120);
         else legs = $urandom_range(1, 24);
         repeat (legs) begin
            pick_waypoint(x, y);
            issue(nws_pkg::MODE_APPEND, x, y);
            if ($urandom_range(29) == 0) issue(MODE_IGNORED, $urandom, $urandom);
            if ($urandom_range(19) == 0) begin
               pick_vehicle(x, y);
               issue(nws_pkg::MODE_QUERY, x, y);
            end
         end
         asks = $urandom_range(1, 8);
         repeat (asks) begin
            pick_vehicle(x, y);
            issue(nws_pkg::MODE_QUERY, x, y);
         end
      end
   endtask

   function automatic void check_field(string what, longint want, longint got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      end
   endfunction

   // Receiver stalls at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin
      target_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_targets.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: result beat with nothing awaited, index %0d count %0d",
                     $time, rsp_target_idx, rsp_point_count);
         end else begin
            want = awaited_targets.pop_front();
            check_field("target_idx", want.index, rsp_target_idx);
            check_field("target_x", want.x, rsp_target_x);
            check_field("target_y", want.y, rsp_target_y);
            check_field("valid_res", want.found, rsp_valid_res);
            check_field("point_count", want.count, rsp_point_count);
            check_field("overflow", want.refused, rsp_overflow);
         end
      end
   end

   initial begin
      #40_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver stalls often
      build_probe_plan();
      foreach (probe_plan[i])
         send_beat(probe_plan[i].mode, probe_plan[i].x, probe_plan[i].y,
                   probe_plan[i].typed, probe_plan[i].want);
      run_routes(185);

      // swap the pressure
      hold_until_drained();
      send_idle_pct = 48;
      stall_pct = 20;
      run_routes(185);

      // back to back
      hold_until_drained();
      send_idle_pct = 0;
      stall_pct = 0;
      run_routes(185);

      hold_until_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
